### hdl/cwc_pkg.sv
// shared types, codes and reset constants of the congestion window controller
package cwc_pkg;

   localparam int WIN_W   = 31;
   localparam int RT_W    = 40;
   localparam int TMO_W   = 48;
   localparam int SEG_W   = 16;
   localparam int DIV_W   = 48;

   // round trip ring depth, kept a power of two so the mean is a shift
   localparam int RING_DEPTH = 8;
   localparam int RING_SHIFT = $clog2(RING_DEPTH);

   localparam logic [WIN_W-1:0] WIN_MAX = {WIN_W{1'b1}};

   // register reset values
   localparam logic [15:0]      RST_SEGMENT   = 16'd1200;
   localparam logic [15:0]      RST_ALPHA     = 16'd256;
   localparam logic [7:0]       RST_BETA      = 8'd128;
   localparam logic [WIN_W-1:0] RST_WINDOW    = 31'd12000;
   localparam logic [WIN_W-1:0] RST_THRESHOLD = 31'h7FFF_FFFF;
   localparam logic [RT_W-1:0]  RST_ROUND_TRIP = 40'd100000000;
   localparam logic [7:0]       RST_TIMEOUT_FACTOR = 8'd2;

   // register indexes
   localparam logic [2:0] REG_SEGMENT   = 3'd0;
   localparam logic [2:0] REG_ALPHA     = 3'd1;
   localparam logic [2:0] REG_BETA      = 3'd2;
   localparam logic [2:0] REG_WINDOW    = 3'd3;
   localparam logic [2:0] REG_THRESHOLD = 3'd4;
   localparam logic [2:0] REG_ROUND_TRIP = 3'd5;
   localparam logic [2:0] REG_TIMEOUT   = 3'd6;

   typedef enum logic [1:0] {
      CMD_ACK    = 2'd0,
      CMD_LOSS   = 2'd1,
      CMD_SEND   = 2'd2,
      CMD_STATUS = 2'd3
   } cmd_code_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_DIVA_GO,
      S_DIVA,
      S_APPLY,
      S_FINISH,
      S_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic div_start;
      logic apply;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic need_div;
   } ctrl_status_type;

endpackage

### hdl/congestion_window_controller.sv
// top level of the congestion window controller
// One item at a time: a request transfer is taken only while the block is idle. The result
// is offered after the states MUL1, MUL2, DIVA_GO, APPLY and FINISH, with DIVA between DIVA_GO
// and APPLY for a matched ack in congestion avoidance, whose window increase runs through a
// 48-step restoring divider. The ring mean is a shift of a running sum. The result stays on
// rsp_tdata until its transfer, after which the next item is taken.
// Register writes take effect at once and are expected only while no item is in flight;
// writing start_round_trip refills the whole ring at once.
module congestion_window_controller (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // byte_count, ack_matched, round_trip_sample, loss_count, zero fill
   input  logic [79:0]  req_tdata,
   // cmd
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // window_bytes, available_bytes, in_avoidance, threshold_bytes,
   // average_round_trip, loss_timeout, send_refused, zero fill
   output logic [183:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [39:0]  csr_data
);
   import cwc_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   logic [WIN_W-1:0] window_bytes, available_bytes, threshold_bytes;
   logic             in_avoidance, send_refused;
   logic [RT_W-1:0]  average_round_trip;
   logic [TMO_W-1:0] loss_timeout;

   assign csr_ready = 1'b1;

   cwc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cwc_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .in_cmd               (req_tuser),
      .in_byte_count        (req_tdata[15:0]),
      .in_ack_matched       (req_tdata[16]),
      .in_round_trip_sample (req_tdata[56:17]),
      .in_loss_count        (req_tdata[72:57]),
      .csr_write            (csr_valid & csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .window_bytes         (window_bytes),
      .available_bytes      (available_bytes),
      .in_avoidance         (in_avoidance),
      .threshold_bytes      (threshold_bytes),
      .average_round_trip   (average_round_trip),
      .loss_timeout         (loss_timeout),
      .send_refused         (send_refused)
   );

   // result packing, lowest field first
   assign rsp_tdata = {1'b0, send_refused, loss_timeout, average_round_trip,
                       threshold_bytes, in_avoidance, available_bytes, window_bytes};

endmodule

### hdl/cwc_divider.sv
// restoring divider, one quotient bit per cycle
module cwc_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [cwc_pkg::DIV_W-1:0] dividend,
   input  logic [cwc_pkg::WIN_W-1:0] divisor,
   output logic [cwc_pkg::DIV_W-1:0] quotient,
   output logic                      done
);
   import cwc_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DIV_W-1:0]   quo_ff;
   logic [WIN_W-1:0]   rem_ff;
   logic [WIN_W-1:0]   div_ff;
   logic [WIN_W:0]     trial;
   logic               fits;
   logic [WIN_W-1:0]   rem_in;

   // one trial subtract per step
   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? WIN_W'(trial - {1'b0, div_ff}) : trial[WIN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            div_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[DIV_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

### hdl/cwc_ctrl.sv
// sequencing state machine of the congestion window controller
module cwc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  cwc_pkg::ctrl_status_type status,
   output cwc_pkg::ctrl_cmd_type    cmd
);
   import cwc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_DIVA_GO;
         end
         S_DIVA_GO: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVA;
            end else begin
               state_in = S_APPLY;
            end
         end
         S_DIVA: begin
            if (status.div_done) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            cmd.out_load = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_done_only_waiting: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> state_ff == S_DIVA)
      else $error("divider finished outside a wait state");
   a_load_then_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_MUL1)
      else $error("item transfer not followed by multiply");
   a_out_after_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.out_load))
      else $error("result shown without being loaded");
`endif

endmodule

### hdl/cwc_datapath.sv
// window, threshold, in-use and round trip datapath
module cwc_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  cwc_pkg::ctrl_cmd_type      cmd,
   output cwc_pkg::ctrl_status_type   status,
   input  logic [1:0]                 in_cmd,
   input  logic [15:0]                in_byte_count,
   input  logic                       in_ack_matched,
   input  logic [cwc_pkg::RT_W-1:0]   in_round_trip_sample,
   input  logic [15:0]                in_loss_count,
   input  logic                       csr_write,
   input  logic [2:0]                 csr_index,
   input  logic [cwc_pkg::RT_W-1:0]   csr_data,
   output logic [cwc_pkg::WIN_W-1:0]  window_bytes,
   output logic [cwc_pkg::WIN_W-1:0]  available_bytes,
   output logic                       in_avoidance,
   output logic [cwc_pkg::WIN_W-1:0]  threshold_bytes,
   output logic [cwc_pkg::RT_W-1:0]   average_round_trip,
   output logic [cwc_pkg::TMO_W-1:0]  loss_timeout,
   output logic                       send_refused
);
   import cwc_pkg::*;

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int SUM_W = RT_W + RING_SHIFT;
   localparam logic [SUM_W-1:0] RST_SUM =
      SUM_W'(RST_ROUND_TRIP) * SUM_W'(RING_DEPTH);

   // configuration
   logic [15:0]      seg_ff, alpha_ff;
   logic [7:0]       beta_ff, tf_ff;
   logic [RT_W-1:0]  start_rt_ff;

   // state
   logic [WIN_W-1:0]      window_ff, in_use_ff, thresh_ff;
   logic                  avoid_ff;
   logic [PTR_W-1:0]      pos_ff;
   logic [RING_DEPTH-1:0] valid_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [RT_W-1:0]       ring_mem [RING_DEPTH];
   logic [RT_W-1:0]       ring_rd_ff;
   logic                  vrd_ff;

   // item and intermediate values
   cmd_code_type      item_cmd_ff;
   logic [15:0]       bytes_ff, losses_ff;
   logic              matched_ff;
   logic [RT_W-1:0]   sample_ff;
   logic [31:0]       as_ff;
   logic [47:0]       big_ff;
   logic [WIN_W-1:0]  scaled_ff;
   logic              refused_ff;

   // result registers
   logic [WIN_W-1:0]  rsp_window_ff, rsp_avail_ff, rsp_thresh_ff;
   logic              rsp_avoid_ff, rsp_refused_ff;
   logic [RT_W-1:0]   rsp_avg_ff;
   logic [TMO_W-1:0]  rsp_timeout_ff;

   // divider
   logic [DIV_W-1:0]  div_dividend, div_quo;
   logic [WIN_W-1:0]  div_divisor;
   logic              div_done;

   // next state of one item
   logic [WIN_W-1:0]  window_in, in_use_in, thresh_in;
   logic              avoid_in, refused_in, ring_we;
   logic [24:0]       ss_inc;
   logic [31:0]       ss_sum;
   logic [WIN_W:0]    ca_sum;
   logic [WIN_W-1:0]  ack_nw, loss_base, loss_nw, avail_now, cur_avail;
   logic [39:0]       scale_prod;
   logic [RT_W-1:0]   ring_old;
   logic [SUM_W-1:0]  sum_in;
   logic [RT_W-1:0]   avg_now;

   cwc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .done     (div_done)
   );

   // divider operands: avoidance increase, zero window taken as one
   assign div_dividend = {8'd0, big_ff[47:8]};
   assign div_divisor  = (window_ff == '0) ? WIN_W'(1) : window_ff;

   // ring mean, depth is a power of two
   assign avg_now = sum_ff[SUM_W-1:RING_SHIFT];

   assign status.div_done = div_done;
   assign status.need_div = (item_cmd_ff == CMD_ACK) && matched_ff && avoid_ff;

   assign scale_prod = 40'(window_ff) * 40'(9'd256 - {1'b0, beta_ff});
   assign ring_old   = vrd_ff ? ring_rd_ff : start_rt_ff;
   assign avail_now  = (window_ff > in_use_ff) ? window_ff - in_use_ff : '0;

   // per-command update
   always_comb begin
      window_in  = window_ff;
      in_use_in  = in_use_ff;
      thresh_in  = thresh_ff;
      avoid_in   = avoid_ff;
      refused_in = 1'b0;
      ring_we    = 1'b0;
      ss_inc     = 25'((33'(as_ff) + 33'd128) >> 8);
      ss_sum     = 32'(window_ff) + 32'(ss_inc);
      ca_sum     = (WIN_W + 1)'(49'(window_ff) + 49'(div_quo) > 49'(WIN_MAX) ?
                   {1'b0, WIN_MAX} : {1'b0, div_quo[WIN_W-1:0]} + {1'b0, window_ff});
      ack_nw     = window_ff;
      loss_base  = scaled_ff;
      loss_nw    = scaled_ff;
      sum_in     = sum_ff;
      case (item_cmd_ff)
         CMD_ACK: begin
            ring_we = 1'b1;
            sum_in  = sum_ff - SUM_W'(ring_old) + SUM_W'(sample_ff);
            if (matched_ff) begin
               if (!avoid_ff) begin
                  ack_nw = ss_sum[WIN_W] ? WIN_MAX : ss_sum[WIN_W-1:0];
                  if (ack_nw >= thresh_ff) begin
                     avoid_in = 1'b1;
                  end
               end else begin
                  ack_nw = ca_sum[WIN_W-1:0];
               end
               window_in = ack_nw;
               in_use_in = (WIN_W'(bytes_ff) >= in_use_ff) ? '0 :
                           in_use_ff - WIN_W'(bytes_ff);
            end
         end
         CMD_LOSS: begin
            if (losses_ff != '0) begin
               if (avoid_ff && losses_ff != 16'd1) begin
                  avoid_in  = 1'b0;
                  thresh_in = scaled_ff;
                  loss_base = WIN_W'(as_ff[31:8]);
               end
               loss_nw   = (loss_base < WIN_W'(seg_ff)) ? WIN_W'(seg_ff) : loss_base;
               window_in = loss_nw;
               in_use_in = (in_use_ff > loss_nw) ? loss_nw : in_use_ff;
            end
         end
         CMD_SEND: begin
            if (WIN_W'(bytes_ff) > avail_now) begin
               refused_in = 1'b1;
            end else begin
               in_use_in = in_use_ff + WIN_W'(bytes_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // ring storage
   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         ring_rd_ff <= ring_mem[pos_ff];
      end
      if (cmd.apply && ring_we) begin
         ring_mem[pos_ff] <= sample_ff;
      end
   end

   // state, configuration and item registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff      <= RST_SEGMENT;
         alpha_ff    <= RST_ALPHA;
         beta_ff     <= RST_BETA;
         tf_ff       <= RST_TIMEOUT_FACTOR;
         start_rt_ff <= RST_ROUND_TRIP;
         window_ff   <= RST_WINDOW;
         thresh_ff   <= RST_THRESHOLD;
         in_use_ff   <= '0;
         avoid_ff    <= 1'b0;
         pos_ff      <= '0;
         valid_ff    <= '0;
         sum_ff      <= RST_SUM;
      end else begin
         if (cmd.apply) begin
            window_ff  <= window_in;
            in_use_ff  <= in_use_in;
            thresh_ff  <= thresh_in;
            avoid_ff   <= avoid_in;
            refused_ff <= refused_in;
            sum_ff     <= sum_in;
            if (ring_we) begin
               valid_ff[pos_ff] <= 1'b1;
               pos_ff <= (pos_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
            end
         end
         // register writes, to be made by the user only while idle; the block does not enforce this
         if (csr_write) begin
            case (csr_index)
               REG_SEGMENT:  seg_ff   <= csr_data[15:0];
               REG_ALPHA:    alpha_ff <= csr_data[15:0];
               REG_BETA:     beta_ff  <= csr_data[7:0];
               REG_WINDOW: begin
                  window_ff <= csr_data[WIN_W-1:0];
                  if (in_use_ff > csr_data[WIN_W-1:0]) begin
                     in_use_ff <= csr_data[WIN_W-1:0];
                  end
               end
               REG_THRESHOLD: thresh_ff <= csr_data[WIN_W-1:0];
               REG_ROUND_TRIP: begin
                  start_rt_ff <= csr_data;
                  valid_ff    <= '0;
                  sum_ff      <= SUM_W'(csr_data) * SUM_W'(RING_DEPTH);
               end
               REG_TIMEOUT: tf_ff <= csr_data[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign cur_avail = avail_now;

   // item capture, arithmetic pipeline and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_cmd_ff <= cmd_code_type'(in_cmd);
         bytes_ff    <= in_byte_count;
         matched_ff  <= in_ack_matched;
         sample_ff   <= in_round_trip_sample;
         losses_ff   <= in_loss_count;
      end
      if (cmd.mul1) begin
         as_ff  <= 32'(alpha_ff) * 32'(seg_ff);
         vrd_ff <= valid_ff[pos_ff];
      end
      if (cmd.mul2) begin
         big_ff    <= 48'(as_ff) * 48'(seg_ff);
         scaled_ff <= scale_prod[38:8];
      end
      if (cmd.out_load) begin
         rsp_window_ff  <= window_ff;
         rsp_avail_ff   <= cur_avail;
         rsp_avoid_ff   <= avoid_ff;
         rsp_thresh_ff  <= thresh_ff;
         rsp_avg_ff     <= avg_now;
         rsp_timeout_ff <= 48'(avg_now) * 48'(tf_ff);
         rsp_refused_ff <= refused_ff;
      end
   end

   assign window_bytes       = rsp_window_ff;
   assign available_bytes    = rsp_avail_ff;
   assign in_avoidance       = rsp_avoid_ff;
   assign threshold_bytes    = rsp_thresh_ff;
   assign average_round_trip = rsp_avg_ff;
   assign loss_timeout       = rsp_timeout_ff;
   assign send_refused       = rsp_refused_ff;

`ifndef SYNTHESIS
   a_in_use_bounded: assert property (@(posedge clock) disable iff (reset)
      in_use_ff <= window_ff)
      else $error("bytes in use exceed the window");
   a_pos_in_ring: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PTR_W'(RING_DEPTH - 1))
      else $error("ring position out of range");
   a_avoid_from_ack: assert property (@(posedge clock) disable iff (reset)
      $rose(avoid_ff) |-> $past(cmd.apply) && item_cmd_ff == CMD_ACK)
      else $error("avoidance entered without an ack");
`endif

endmodule
